// ===== src/cwof_pkg.sv =====
`timescale 1ns / 1ps

package cwof_pkg;

    // Sizes of the scan and of the coefficient table.
    localparam int MAX_WINDOW     = 20;
    localparam int MIN_WINDOW     = 3;
    localparam int MAX_SAMPLES    = 256;
    localparam int COEF_FRAC_BITS = 20;

    // Field widths.
    localparam int WS_W     = 5;
    localparam int CURV_W   = 37;
    localparam int ANGLE_W  = 12;
    localparam int DIST_W   = 14;
    localparam int BANGLE_W = 16;
    localparam int IDX_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int TAP_W    = $clog2(MAX_WINDOW);

    // Coefficient table: one row per window length, one column per distinct |u|.
    localparam int ROM_ROWS = MAX_WINDOW - MIN_WINDOW + 1;
    localparam int ROM_COLS = (MAX_WINDOW + 1) / 2;
    localparam int ROW_W    = $clog2(ROM_ROWS);
    localparam int COL_W    = $clog2(ROM_COLS);
    localparam int COEF_W   = COEF_FRAC_BITS + 2;

    // Datapath widths of the multiply-accumulate.
    localparam int PROD_W = COEF_W + DIST_W + 1;
    localparam int ACC_W  = CURV_W + 3;

    // Stream widths.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = CURV_W + 1 + IDX_W + BANGLE_W + DIST_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CURV_W;

    // Command queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    // Distance reported when no window qualified.
    localparam logic [DIST_W-1:0] NONE_DIST = DIST_W'(10000);

    // Result kinds carried on tuser.
    localparam logic KIND_WINDOW   = 1'b0;
    localparam logic KIND_DECISION = 1'b1;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_MIN_CURV    = 2'd1,
        REG_FROM_ANGLE  = 2'd2,
        REG_STEP_ANGLE  = 2'd3
    } cfg_reg_t;

    // What the back end does with a queued sample.
    typedef enum logic [1:0] {
        CMD_STORE  = 2'd0,
        CMD_WINDOW = 2'd1,
        CMD_DECIDE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [DIST_W-1:0]  distance;
        logic [WS_W-1:0]    win_n;
        logic [IDX_W-1:0]   centre;
    } cmd_t;

    // Registers the back end reads.
    typedef struct packed {
        logic signed [CURV_W-1:0]  min_curvature;
        logic signed [ANGLE_W-1:0] from_angle;
        logic signed [ANGLE_W-1:0] step_angle;
    } back_cfg_t;

endpackage

// ===== src/curvature_window_object_finder.sv =====
`timescale 1ns / 1ps

// Curvature window object finder. Each input beat carries one range reading of a scan
// (distance in tdata, tlast on the final reading). A front end counts the readings and
// classifies each beat, and a four-entry command queue hands it to the back end, so the
// input keeps accepting beats while the queue has room, also while results are formed
// or wait to be taken. The back end keeps the last window_size readings and, for every
// completed window, runs one shared multiply-accumulate over the quadratic-fit
// coefficient table, one tap per cycle. It takes the next queued reading only once it
// has handed the current window's result to the output register, so that
// multiply-accumulate sets the sustained rate once windows complete. Each window gives a
// result beat with tuser 0 and its curvature; the final reading gives a decision beat
// with tuser 1 and clears the scan. Registers are to be written through the cfg port
// only while the block is idle, which the block does not enforce; cfg_ready is always high.
module curvature_window_object_finder
    import cwof_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // distance [13:0], zeros above
    input  logic                   s_axis_tlast,   // is_last
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // curvature [36:0], found [37], best_index [45:38], best_angle [61:46],
    // best_distance [75:62], zeros [79:76]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,   // kind
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [WS_W-1:0]           window_size_reg;
    logic signed [CURV_W-1:0]  min_curv_reg;
    logic signed [ANGLE_W-1:0] from_angle_reg;
    logic signed [ANGLE_W-1:0] step_angle_reg;
    back_cfg_t                 back_cfg;
    logic                      fifo_full;
    logic                      fifo_empty;
    logic                      push;
    logic                      pop;
    cmd_t                      push_cmd;
    cmd_t                      pop_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WS_W'(5);
            min_curv_reg    <= '0;
            from_angle_reg  <= ANGLE_W'(-480);
            step_angle_reg  <= ANGLE_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WS_W-1:0];
                REG_MIN_CURV:    min_curv_reg    <= cfg_data[CURV_W-1:0];
                REG_FROM_ANGLE:  from_angle_reg  <= cfg_data[ANGLE_W-1:0];
                REG_STEP_ANGLE:  step_angle_reg  <= cfg_data[ANGLE_W-1:0];
                default:         window_size_reg <= window_size_reg;
            endcase
        end
    end

    always_comb
    begin
        back_cfg.min_curvature = min_curv_reg;
        back_cfg.from_angle    = from_angle_reg;
        back_cfg.step_angle    = step_angle_reg;
    end

    cwof_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .window_size   (window_size_reg),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    cwof_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    cwof_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (back_cfg),
        .fifo_empty    (fifo_empty),
        .pop           (pop),
        .pop_cmd       (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== src/cwof_front.sv =====
`timescale 1ns / 1ps

module cwof_front
    import cwof_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // distance [13:0], zeros above
    input  logic                  s_axis_tlast,
    input  logic [WS_W-1:0]       window_size,
    input  logic                  fifo_full,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic             room;
    logic [WS_W-1:0]  win_n;
    logic [CNT_W:0]   filled;
    logic [CNT_W:0]   centre_full;

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign room          = count_reg < CNT_W'(MAX_SAMPLES);

    // Window length in force, pinned to the table's range.
    always_comb
    begin
        if (window_size < WS_W'(MIN_WINDOW))
            win_n = WS_W'(MIN_WINDOW);
        else if (window_size > WS_W'(MAX_WINDOW))
            win_n = WS_W'(MAX_WINDOW);
        else
            win_n = window_size;
    end

    // Classify the beat: final sample, sample that completes a window, or plain store.
    always_comb
    begin
        filled      = {1'b0, count_reg} + (CNT_W + 1)'(1);
        centre_full = filled - (CNT_W + 1)'(win_n) + (CNT_W + 1)'(win_n >> 1);

        push_cmd.distance = s_axis_tdata[DIST_W-1:0];
        push_cmd.win_n    = win_n;
        push_cmd.centre   = centre_full[IDX_W-1:0];
        if (s_axis_tlast)
            push_cmd.kind = CMD_DECIDE;
        else if (filled >= (CNT_W + 1)'(win_n))
            push_cmd.kind = CMD_WINDOW;
        else
            push_cmd.kind = CMD_STORE;

        push = accept && (s_axis_tlast || room);
    end

    // Sample counter of the current scan.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (s_axis_tlast)
                count_next = '0;
            else if (room)
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// ===== src/cwof_cmd_fifo.sv =====
`timescale 1ns / 1ps

module cwof_cmd_fifo
    import cwof_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_LVL_W-1:0] level_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = level_reg == FIFO_LVL_W'(FIFO_DEPTH);
    assign empty   = level_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (do_push && !do_pop)
                level_reg <= level_reg + FIFO_LVL_W'(1);
            else if (do_pop && !do_push)
                level_reg <= level_reg - FIFO_LVL_W'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // The fill level never passes the depth.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= FIFO_LVL_W'(FIFO_DEPTH))
        else $error("command queue level exceeds its depth");

endmodule

// ===== src/cwof_coef_rom.sv =====
`timescale 1ns / 1ps

module cwof_coef_rom
    import cwof_pkg::*;
(
    input  logic [WS_W-1:0]          win_n,
    input  logic [COL_W-1:0]         col,
    output logic signed [COEF_W-1:0] coef
);

    logic signed [COEF_W-1:0] rom [ROM_ROWS][ROM_COLS];
    logic [ROW_W-1:0]         row;

    // Quadratic-fit coefficient for window n at offset u = 2j-(n-1):
    // 15*(3u^2 - (n^2-1)) / (n(n^2-1)(n^2-4)), scaled and rounded half away from zero.
    // The row only depends on |u|, so column m holds |u| = 2m (odd n) or 2m+1 (even n).
    for (genvar gn = MIN_WINDOW; gn <= MAX_WINDOW; gn++)
    begin : g_row
        for (genvar gm = 0; gm < ROM_COLS; gm++)
        begin : g_col
            localparam longint U    = 2 * gm + 1 - (gn % 2);
            localparam longint NUMR = longint'(15) * (3 * U * U - longint'(gn) * gn + 1)
                                      * (longint'(1) <<< COEF_FRAC_BITS);
            localparam longint DEN  = longint'(gn) * (gn * gn - 1) * (gn * gn - 4);
            localparam longint MAG  = ((NUMR < 0 ? -NUMR : NUMR) + DEN / 2) / DEN;
            localparam longint VAL  = (U < gn) ? ((NUMR < 0) ? -MAG : MAG) : 0;
            assign rom[gn - MIN_WINDOW][gm] = COEF_W'(VAL);
        end
    end

    assign row  = ROW_W'(win_n - WS_W'(MIN_WINDOW));
    assign coef = rom[row][col];

endmodule

// ===== src/cwof_back.sv =====
`timescale 1ns / 1ps

module cwof_back
    import cwof_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  back_cfg_t              cfg,
    input  logic                   fifo_empty,
    output logic                   pop,
    input  cmd_t                   pop_cmd,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // curvature [36:0], found [37], best_index [45:38], best_angle [61:46],
    // best_distance [75:62], zeros [79:76]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser    // kind
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MAC    = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_DECIDE = 5'b10000
    } back_state_t;

    localparam logic signed [ACC_W-1:0] ACC_CURV_MAX =
        ACC_W'((longint'(1) <<< (CURV_W - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] ACC_CURV_MIN =
        ACC_W'(-(longint'(1) <<< (CURV_W - 1)));
    localparam int ANG_PROD_W = ANGLE_W + IDX_W + 1;
    localparam int ANG_SUM_W  = ANG_PROD_W + 1;
    localparam logic signed [ANG_SUM_W-1:0] ANG_MAX =
        ANG_SUM_W'((longint'(1) <<< (BANGLE_W - 1)) - longint'(1));
    localparam logic signed [ANG_SUM_W-1:0] ANG_MIN =
        ANG_SUM_W'(-(longint'(1) <<< (BANGLE_W - 1)));

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [DIST_W-1:0]         win_reg [MAX_WINDOW];
    logic [WS_W-1:0]           win_n_reg;
    logic [IDX_W-1:0]          centre_reg;
    logic [TAP_W-1:0]          tap_j_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [COEF_W-1:0]  coef_reg;
    logic [DIST_W-1:0]         samp_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [DIST_W-1:0]         cdist_reg;
    logic [DIST_W-1:0]         best_dist_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic                      found_reg;
    logic                      out_valid_reg;
    logic                      out_kind_reg;
    logic [OUT_TDATA_W-1:0]    out_data_reg;

    logic                      out_free;
    logic                      shift_in;
    logic                      start_mac;
    logic                      issue;
    logic                      last_tap;
    logic                      emit_window;
    logic                      emit_decision;
    logic [WS_W-1:0]           tap_addr;
    logic [TAP_W:0]            two_j;
    logic [TAP_W:0]            n_m1;
    logic [TAP_W:0]            u_mag;
    logic [COL_W-1:0]          col;
    logic signed [COEF_W-1:0]  rom_coef;
    logic [DIST_W-1:0]         tap_sample;
    logic signed [CURV_W-1:0]  curv_sat;
    logic                      pass;
    logic signed [ANG_PROD_W-1:0] ang_prod;
    logic signed [ANG_SUM_W-1:0]  ang_sum;
    logic signed [BANGLE_W-1:0]   ang_sat;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    // Tap j of the window sits at win_reg[n-1-j]; its coefficient column is |2j-(n-1)|/2.
    assign tap_addr   = win_n_reg - WS_W'(1) - WS_W'(tap_j_reg);
    assign tap_sample = win_reg[tap_addr[TAP_W-1:0]];
    assign two_j      = {tap_j_reg, 1'b0};
    assign n_m1       = (TAP_W + 1)'(win_n_reg - WS_W'(1));
    assign u_mag      = (two_j >= n_m1) ? (two_j - n_m1) : (n_m1 - two_j);
    assign col        = u_mag[COL_W:1];
    assign last_tap   = WS_W'(tap_j_reg) == (win_n_reg - WS_W'(1));

    cwof_coef_rom u_coef_rom (
        .win_n (win_n_reg),
        .col   (col),
        .coef  (rom_coef)
    );

    // Saturated curvature and the test for a new best window.
    always_comb
    begin
        if (acc_reg > ACC_CURV_MAX)
            curv_sat = CURV_W'(ACC_CURV_MAX);
        else if (acc_reg < ACC_CURV_MIN)
            curv_sat = CURV_W'(ACC_CURV_MIN);
        else
            curv_sat = CURV_W'(acc_reg);
        pass = (curv_sat >= cfg.min_curvature) && (cdist_reg < best_dist_reg);
    end

    // Decision angle: start angle plus centre index times step, saturated to 16 bits.
    always_comb
    begin
        ang_prod = $signed({1'b0, best_idx_reg}) * cfg.step_angle;
        ang_sum  = ANG_SUM_W'(ang_prod) + ANG_SUM_W'(cfg.from_angle);
        if (ang_sum > ANG_MAX)
            ang_sat = BANGLE_W'(ANG_MAX);
        else if (ang_sum < ANG_MIN)
            ang_sat = BANGLE_W'(ANG_MIN);
        else
            ang_sat = BANGLE_W'(ang_sum);
    end

    // Sequencer: take a command, run the taps through the shared multiplier, report.
    always_comb
    begin
        state_next    = state_reg;
        pop           = 1'b0;
        shift_in      = 1'b0;
        start_mac     = 1'b0;
        issue         = 1'b0;
        emit_window   = 1'b0;
        emit_decision = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop = 1'b1;
                    case (pop_cmd.kind)
                        CMD_STORE:
                        begin
                            shift_in = 1'b1;
                        end
                        CMD_WINDOW:
                        begin
                            shift_in   = 1'b1;
                            start_mac  = 1'b1;
                            state_next = ST_MAC;
                        end
                        CMD_DECIDE:
                        begin
                            state_next = ST_DECIDE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                issue = 1'b1;
                if (last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    emit_window = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    emit_decision = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: sequencer, pipeline valids, best window, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            best_dist_reg <= NONE_DIST;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (emit_window && pass)
            begin
                best_dist_reg <= cdist_reg;
                best_idx_reg  <= centre_reg;
                found_reg     <= 1'b1;
            end
            else if (emit_decision)
            begin
                best_dist_reg <= NONE_DIST;
                best_idx_reg  <= '0;
                found_reg     <= 1'b0;
            end
            if (emit_window || emit_decision)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Sample window shift line.
    always_ff @(posedge clk)
    begin
        if (shift_in)
        begin
            win_reg[0] <= pop_cmd.distance;
            for (int i = 1; i < MAX_WINDOW; i++)
                win_reg[i] <= win_reg[i-1];
        end
    end

    // Multiply-accumulate datapath: table read, multiply, accumulate.
    always_ff @(posedge clk)
    begin
        if (start_mac)
        begin
            win_n_reg  <= pop_cmd.win_n;
            centre_reg <= pop_cmd.centre;
            tap_j_reg  <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            if (issue)
                tap_j_reg <= tap_j_reg + TAP_W'(1);
            if (v2_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (issue)
        begin
            coef_reg <= rom_coef;
            samp_reg <= tap_sample;
            if (tap_j_reg == TAP_W'(win_n_reg >> 1))
                cdist_reg <= tap_sample;
        end
        if (v1_reg)
            prod_reg <= coef_reg * $signed({1'b0, samp_reg});
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (emit_window)
        begin
            out_kind_reg <= KIND_WINDOW;
            out_data_reg <= {{OUT_PAD_W{1'b0}}, {DIST_W{1'b0}}, {BANGLE_W{1'b0}},
                             {IDX_W{1'b0}}, 1'b0, curv_sat};
        end
        else if (emit_decision)
        begin
            out_kind_reg <= KIND_DECISION;
            if (found_reg)
                out_data_reg <= {{OUT_PAD_W{1'b0}}, best_dist_reg, ang_sat,
                                 best_idx_reg, 1'b1, {CURV_W{1'b0}}};
            else
                out_data_reg <= {{OUT_PAD_W{1'b0}}, NONE_DIST, {BANGLE_W{1'b0}},
                                 {IDX_W{1'b0}}, 1'b0, {CURV_W{1'b0}}};
        end
    end

    // The tap counter stays inside the window while taps are issued.
    a_tap_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (WS_W'(tap_j_reg) < win_n_reg))
        else $error("tap index ran past the window length");

    // A window result is only formed once the multiply pipeline has drained.
    a_drained_before_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (!v1_reg && !v2_reg))
        else $error("window result formed with products still in flight");

    // Without a qualifying window the best distance stays at its none value.
    a_best_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> (best_dist_reg == NONE_DIST && best_idx_reg == '0))
        else $error("best window recorded without the found flag");

endmodule
